/* src/nvs_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest vertex search package
// Shared sizes, command codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package nvs_pkg;

  // Store geometry and coordinate format.
  localparam int MAX_VERTICES = 4096;
  localparam int COORD_WIDTH  = 16;
  localparam int NUM_SETS     = 3;

  // Fixed field widths of the ports.
  localparam int PT_W   = 16;
  localparam int SET_W  = 2;
  localparam int VIDX_W = 12;
  localparam int CNT_W  = 13;
  localparam int DIST_W = 17;

  // Derived sizes.
  localparam int SIDX_W = $clog2(MAX_VERTICES);
  localparam int SCAN_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (SCAN_W > CNT_W) ? SCAN_W : CNT_W;
  localparam int ADDR_W = $clog2(NUM_SETS * MAX_VERTICES);
  localparam int VTX_W  = 3 * COORD_WIDTH;
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * MAG_W + 2;
  localparam int LOW_W  = (SQ_W > 39) ? SQ_W : 39;

  // One past the highest valid set code.
  localparam logic [SET_W-1:0] SET_LIMIT = SET_W'(NUM_SETS);

  // Starting best distance: 256*256*256 mm^2 in (1/128 mm)^2 units.
  localparam logic [LOW_W-1:0] LOWEST_INIT =
    LOW_W'((64'd256 * 64'd256 * 64'd256) * 64'd128 * 64'd128);

  // Item command codes.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic sqrt_load;
    logic sqrt_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic sqrt_last;
  } dp_status_t;

  // Reinterpret a coordinate field as a COORD_WIDTH signed value.
  function automatic logic signed [COORD_WIDTH-1:0] coord_of(input logic [PT_W-1:0] raw);
    logic [COORD_WIDTH+PT_W-1:0] ext;
    ext = {{COORD_WIDTH{1'b0}}, raw};
    return $signed(ext[COORD_WIDTH-1:0]);
  endfunction

endpackage

/* src/nvs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nvs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12288
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/nvs_regs.sv */
// ----------------------------------------------------------------------------
// Nearest vertex search configuration registers
// APB-style register file holding the vertex count.
// ----------------------------------------------------------------------------
module nvs_regs import nvs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] vertex_count
);

  localparam logic REG_VERTEX_COUNT = 1'b0;

  logic             reg_index;
  logic             wr_en;
  logic [CNT_W-1:0] vertex_count_r;
  logic [CNT_W-1:0] vertex_count_nxt;

  // Word index of the access.
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register update.
  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (wr_en) begin
      unique case (reg_index)
        REG_VERTEX_COUNT: vertex_count_nxt = pwdata[CNT_W-1:0];
        default:          vertex_count_nxt = vertex_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else begin
      vertex_count_r <= vertex_count_nxt;
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_index)
      REG_VERTEX_COUNT: prdata = 32'(vertex_count_r);
      default:          prdata = '0;
    endcase
  end

  assign vertex_count = vertex_count_r;

endmodule

/* src/nvs_dp.sv */
// ----------------------------------------------------------------------------
// Nearest vertex search datapath
// Vertex store, distance pipeline, best-candidate tracking and square root.
// ----------------------------------------------------------------------------
module nvs_dp import nvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic                    wr_accept,
  input  logic [SET_W-1:0]        in_vertex_set,
  input  logic [VIDX_W-1:0]       in_vertex_index,
  input  logic signed [PT_W-1:0]  in_point_x,
  input  logic signed [PT_W-1:0]  in_point_y,
  input  logic signed [PT_W-1:0]  in_point_z,
  input  logic [CNT_W-1:0]        vertex_count,
  output logic                    out_found,
  output logic [VIDX_W-1:0]       out_best_index,
  output logic [DIST_W-1:0]       out_distance
);

  // Query context.
  logic signed [COORD_WIDTH-1:0] px_r, py_r, pz_r;
  logic [SET_W-1:0]              set_r;
  logic [SCAN_W-1:0]             n_r;
  logic [SCAN_W-1:0]             cnt_r;
  logic [SCAN_W-1:0]             n_nxt;
  logic [CMP_W-1:0]              count_ext;
  logic [CMP_W-1:0]              max_ext;

  // Store ports.
  logic                          we;
  logic [ADDR_W-1:0]             waddr;
  logic [ADDR_W-1:0]             raddr;
  logic [VTX_W-1:0]              wdata;
  logic [VTX_W-1:0]              rdata;

  // Pipeline stages.
  logic                          v0_r, v1_r, v2_r;
  logic [SIDX_W-1:0]             idx0_r, idx1_r, idx2_r;
  logic [MAG_W-1:0]              mag_x_r, mag_y_r, mag_z_r;
  logic [2*MAG_W-1:0]            sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]               dist_sq;

  // Best candidate.
  logic                          found_r;
  logic [SIDX_W-1:0]             best_r;
  logic [LOW_W-1:0]              lowest_r;

  // Square root unit.
  logic [SQ_W-1:0]               rem_r;
  logic [SQ_W-1:0]               root_r;
  logic [SQ_W-1:0]               bit_r;
  logic [SQ_W:0]                 trial;
  logic [SQ_W:0]                 diff;

  // Absolute difference of two coordinates.
  function automatic logic [MAG_W-1:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(a) - MAG_W'(b);
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // Store write straight from an accepted write item.
  assign we    = wr_accept && (in_vertex_set < SET_LIMIT) &&
                 (32'(in_vertex_index) < 32'(MAX_VERTICES));
  assign waddr = ADDR_W'(in_vertex_set) * ADDR_W'(MAX_VERTICES) + ADDR_W'(in_vertex_index);
  assign wdata = {coord_of(in_point_z), coord_of(in_point_y), coord_of(in_point_x)};
  assign raddr = ADDR_W'(set_r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(cnt_r[SIDX_W-1:0]);

  nvs_ram #(
    .WIDTH (VTX_W),
    .DEPTH (NUM_SETS * MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Scan length, clipped to the store size; an invalid set scans nothing.
  assign count_ext = CMP_W'(vertex_count);
  assign max_ext   = CMP_W'(MAX_VERTICES);
  always_comb begin
    n_nxt = '0;
    if (in_vertex_set < SET_LIMIT) begin
      n_nxt = (count_ext > max_ext) ? SCAN_W'(max_ext) : SCAN_W'(count_ext);
    end
  end

  // Query context and scan counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r  <= coord_of(in_point_x);
      py_r  <= coord_of(in_point_y);
      pz_r  <= coord_of(in_point_z);
      set_r <= in_vertex_set;
      n_r   <= n_nxt;
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + SCAN_W'(1);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Absolute differences, then squares.
  always_ff @(posedge clk) begin
    idx0_r  <= cnt_r[SIDX_W-1:0];
    idx1_r  <= idx0_r;
    idx2_r  <= idx1_r;
    mag_x_r <= abs_diff(px_r, $signed(rdata[COORD_WIDTH-1:0]));
    mag_y_r <= abs_diff(py_r, $signed(rdata[2*COORD_WIDTH-1:COORD_WIDTH]));
    mag_z_r <= abs_diff(pz_r, $signed(rdata[3*COORD_WIDTH-1:2*COORD_WIDTH]));
    sq_x_r  <= mag_x_r * mag_x_r;
    sq_y_r  <= mag_y_r * mag_y_r;
    sq_z_r  <= mag_z_r * mag_z_r;
  end

  // Sum and keep the first strict minimum.
  assign dist_sq = SQ_W'(sq_x_r) + SQ_W'(sq_y_r) + SQ_W'(sq_z_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r  <= 1'b0;
      best_r   <= '0;
      lowest_r <= LOWEST_INIT;
    end else if (v2_r && (LOW_W'(dist_sq) < lowest_r)) begin
      found_r  <= 1'b1;
      best_r   <= idx2_r;
      lowest_r <= LOW_W'(dist_sq);
    end
  end

  // Square root, two radicand bits per cycle.
  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign diff  = {1'b0, rem_r} - trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      rem_r  <= lowest_r[SQ_W-1:0];
      root_r <= '0;
      bit_r  <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (!diff[SQ_W]) begin
        rem_r  <= diff[SQ_W-1:0];
        root_r <= (root_r >> 1) | bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Status back to the controller.
  assign status.issue_done = (cnt_r == n_r);
  assign status.pipe_empty = !v0_r && !v1_r && !v2_r;
  assign status.sqrt_last  = bit_r[0];

  // Result fields.
  assign out_found      = found_r;
  assign out_best_index = found_r ? VIDX_W'(best_r) : '0;
  assign out_distance   = found_r ? DIST_W'(root_r) : '0;

endmodule

/* src/nvs_ctrl.sv */
// ----------------------------------------------------------------------------
// Nearest vertex search controller
// Sequences the scan, pipeline drain, square root and result strobe.
// ----------------------------------------------------------------------------
module nvs_ctrl import nvs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_command,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       wr_accept,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SQRT
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;
  logic   accept;

  assign accept    = start && !busy_r;
  assign wr_accept = accept && (in_command == CMD_WRITE);

  // Datapath commands decoded from the state.
  always_comb begin
    cmd.load      = (state_r == S_IDLE) && accept && (in_command == CMD_QUERY);
    cmd.issue     = (state_r == S_SCAN) && !status.issue_done;
    cmd.sqrt_load = (state_r == S_DRAIN) && status.pipe_empty;
    cmd.sqrt_step = (state_r == S_SQRT);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_command == CMD_QUERY)) begin
            state_r <= S_SCAN;
            busy_r  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (status.issue_done) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (status.pipe_empty) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (status.sqrt_last) begin
            state_r     <= S_IDLE;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  // Busy is exactly the non-idle states.
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy does not match controller state");

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // A result follows the last square root step.
  a_strobe_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_SQRT))
    else $error("result strobe without square root");

  // The square root only runs on a drained pipeline.
  a_sqrt_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> status.pipe_empty)
    else $error("square root started before the pipeline drained");

endmodule

/* src/nearest_vertex_search_top.sv */
// ----------------------------------------------------------------------------
// Nearest vertex search top level
// Brute-force 3-D nearest vertex search over three stored coordinate sets.
//
//   Channel   Handshake              Payload
//   input     start / busy           in_command, in_vertex_set, in_vertex_index,
//                                    in_point_x, in_point_y, in_point_z
//   result    out_valid (one cycle)  out_found, out_best_index, out_distance
//   config    APB psel/penable       paddr, pwdata, prdata (vertex_count)
//
// A write item is written to the vertex store and leaves busy low.
// A query item scans min(vertex_count, 4096) vertices of its set, or none for an invalid set: the
// scan reads one vertex per cycle from the single read port of the vertex store,
// then the four-stage distance pipeline drains and the square root runs 18 steps.
// The result strobe comes in the first cycle with busy low; the receiver cannot stall.
// Reset is synchronous and active low; the vertex store is not cleared.
// ----------------------------------------------------------------------------
module nearest_vertex_search_top import nvs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_command,
  input  logic [SET_W-1:0]       in_vertex_set,
  input  logic [VIDX_W-1:0]      in_vertex_index,
  input  logic signed [PT_W-1:0] in_point_x,
  input  logic signed [PT_W-1:0] in_point_y,
  input  logic signed [PT_W-1:0] in_point_z,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [VIDX_W-1:0]      out_best_index,
  output logic [DIST_W-1:0]      out_distance,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             wr_accept;
  logic [CNT_W-1:0] vertex_count;

  // Configuration registers.
  nvs_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count)
  );

  // Controller.
  nvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd),
    .wr_accept  (wr_accept),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // Datapath.
  nvs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .wr_accept       (wr_accept),
    .in_vertex_set   (in_vertex_set),
    .in_vertex_index (in_vertex_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .vertex_count    (vertex_count),
    .out_found       (out_found),
    .out_best_index  (out_best_index),
    .out_distance    (out_distance)
  );

endmodule
